// ===== rtl/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// RC4 package
// Shared constants and types for the RC4 stream cipher block.
// ----------------------------------------------------------------------------
package rc4_pkg;

  // Key storage limits.
  localparam int MaxKeyBytes = 16;
  localparam int KeyLenW     = $clog2(MaxKeyBytes + 1);
  localparam int KeyIdxW     = $clog2(MaxKeyBytes);

  // Permutation geometry.
  localparam int PermSize = 256;
  localparam int ByteW    = 8;

  // Configuration port geometry: 64-bit registers at 8-byte spacing.
  localparam int CfgDataW = 64;
  localparam int CfgAddrW = 5;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] RegKeyLow  = 2'd0;
  localparam logic [1:0] RegKeyHigh = 2'd1;
  localparam logic [1:0] RegKeyLen  = 2'd2;

  // Key as seen by the sequencer: bytes plus the clamped length.
  typedef logic [MaxKeyBytes-1:0][ByteW-1:0] key_bytes_t;

  typedef struct packed {
    key_bytes_t         bytes;
    logic [KeyLenW-1:0] len;
  } key_cfg_t;

endpackage

// ===== rtl/rc4_if.sv =====
// ----------------------------------------------------------------------------
// RC4 stream channels
// Valid/ready channels for data bytes entering and results leaving the block.
// ----------------------------------------------------------------------------

// Input channel: one data byte and a restart flag per transfer.
interface rc4_in_if;
  logic                     valid;
  logic                     ready;
  logic [rc4_pkg::ByteW-1:0] data_byte;
  logic                     restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

// Output channel: the combined byte and the keystream byte per transfer.
interface rc4_out_if;
  logic                     valid;
  logic                     ready;
  logic [rc4_pkg::ByteW-1:0] result_byte;
  logic [rc4_pkg::ByteW-1:0] keystream_byte;

  modport source (output valid, output result_byte, output keystream_byte, input ready);
  modport sink   (input valid, input result_byte, input keystream_byte, output ready);
endinterface

// ===== rtl/rc4_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Each input byte is combined with the next RC4 keystream byte. The key (up to
// 16 bytes) and its length are set over the APB port at 0x00 (bytes 0-7),
// 0x08 (bytes 8-15) and 0x10 (length; 0 acts as 1, above 16 acts as 16); the
// key takes effect at the next key schedule, which runs on the first byte
// after reset and on every byte that carries restart. Once a byte is taken,
// the block is not ready again until the dependent reads and writes of S[i],
// S[j] and S[S[i]+S[j]] on the permutation RAM, which has one read port and
// one write port, are done and the result is handed on. A key schedule first
// fills the permutation and then makes 256 swap steps of four RAM accesses
// each. A finished result sits in an output register, so the next byte is
// taken while it waits.
// ----------------------------------------------------------------------------
module rc4_stream_cipher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rc4_pkg::CfgAddrW-1:0]  paddr,
  input  logic [rc4_pkg::CfgDataW-1:0]  pwdata,
  output logic [rc4_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  rc4_in_if.sink                        in_i,
  rc4_out_if.source                     out_o
);

  logic [rc4_pkg::CfgDataW-1:0] key_lo_q, key_hi_q;
  logic [rc4_pkg::KeyLenW-1:0]  key_len_q;
  logic [1:0]                   reg_idx;
  logic                         cfg_write;
  rc4_pkg::key_cfg_t            key_cfg;

  assign reg_idx   = paddr[4:3];
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q  <= '0;
      key_hi_q  <= '0;
      key_len_q <= rc4_pkg::KeyLenW'(rc4_pkg::MaxKeyBytes);
    end else if (cfg_write) begin
      case (reg_idx)
        rc4_pkg::RegKeyLow:  key_lo_q  <= pwdata;
        rc4_pkg::RegKeyHigh: key_hi_q  <= pwdata;
        rc4_pkg::RegKeyLen:  key_len_q <= pwdata[rc4_pkg::KeyLenW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      rc4_pkg::RegKeyLow:  prdata = key_lo_q;
      rc4_pkg::RegKeyHigh: prdata = key_hi_q;
      rc4_pkg::RegKeyLen:  prdata = rc4_pkg::CfgDataW'(key_len_q);
      default:             prdata = '0;
    endcase
  end

  // Key as used by the schedule, with the length clamped to 1..16.
  always_comb begin
    key_cfg.bytes = {key_hi_q, key_lo_q};
    if (key_len_q == '0) begin
      key_cfg.len = rc4_pkg::KeyLenW'(1);
    end else if (key_len_q > rc4_pkg::KeyLenW'(rc4_pkg::MaxKeyBytes)) begin
      key_cfg.len = rc4_pkg::KeyLenW'(rc4_pkg::MaxKeyBytes);
    end else begin
      key_cfg.len = key_len_q;
    end
  end

  rc4_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

// ===== rtl/rc4_core.sv =====
// ----------------------------------------------------------------------------
// RC4 core
// Sequencer around one 256x8 permutation RAM: key schedule and byte steps.
// ----------------------------------------------------------------------------
module rc4_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rc4_pkg::key_cfg_t key_i,
  rc4_in_if.sink            in_i,
  rc4_out_if.source         out_o
);

  localparam int BW = rc4_pkg::ByteW;

  // Sequencer state codes.
  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StInit    = 4'd1;
  localparam logic [3:0] StKsRead  = 4'd2;
  localparam logic [3:0] StKsAdd   = 4'd3;
  localparam logic [3:0] StKsWrN   = 4'd4;
  localparam logic [3:0] StKsWrJ   = 4'd5;
  localparam logic [3:0] StGenI    = 4'd6;
  localparam logic [3:0] StGenJ    = 4'd7;
  localparam logic [3:0] StGenWrI  = 4'd8;
  localparam logic [3:0] StGenWrJ  = 4'd9;
  localparam logic [3:0] StDeliver = 4'd10;

  logic [3:0]                   state_q, state_d;
  logic [BW-1:0]                n_q, n_d;
  logic [rc4_pkg::KeyIdxW-1:0]  k_q, k_d;
  logic [BW-1:0]                i_q, i_d;
  logic [BW-1:0]                j_q, j_d;
  logic                         keyed_q, keyed_d;
  logic [BW-1:0]                si_q, si_d;
  logic [BW-1:0]                sj_q, sj_d;
  logic [BW-1:0]                t_q, t_d;
  logic [BW-1:0]                ks_q, ks_d;
  logic [BW-1:0]                data_q, data_d;
  logic                         out_valid_q, out_valid_d;
  logic [BW-1:0]                out_res_q, out_res_d;
  logic [BW-1:0]                out_ks_q, out_ks_d;

  // Permutation RAM signals.
  logic [BW-1:0] sbox_mem [rc4_pkg::PermSize];
  logic          mem_we;
  logic [BW-1:0] mem_waddr, mem_wdata, mem_raddr, mem_rdata_q;

  logic          in_xfer;
  logic          out_free;
  logic [BW-1:0] key_byte;
  logic [BW-1:0] sum;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign key_byte = key_i.bytes[k_q];

  // Permutation RAM: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sbox_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= sbox_mem[mem_raddr];
  end

  // Sequencer next-state and datapath control.
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    k_d         = k_q;
    i_d         = i_q;
    j_d         = j_q;
    keyed_d     = keyed_q;
    si_d        = si_q;
    sj_d        = sj_q;
    t_d         = t_q;
    ks_d        = ks_q;
    data_d      = data_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    out_ks_d    = out_ks_q;
    mem_we      = 1'b0;
    mem_waddr   = n_q;
    mem_wdata   = n_q;
    mem_raddr   = n_q;
    sum         = '0;

    // The output register is emptied by a transfer on the output side.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          data_d = in_i.data_byte;
          n_d    = '0;
          if (in_i.restart || !keyed_q) begin
            state_d = StInit;
          end else begin
            state_d = StGenI;
          end
        end
      end
      // Fill the permutation with the identity, one entry a cycle.
      StInit: begin
        mem_we    = 1'b1;
        mem_waddr = n_q;
        mem_wdata = n_q;
        n_d       = n_q + BW'(1);
        if (n_q == BW'(rc4_pkg::PermSize - 1)) begin
          j_d     = '0;
          k_d     = '0;
          state_d = StKsRead;
        end
      end
      // Key schedule: read S[n].
      StKsRead: begin
        mem_raddr = n_q;
        state_d   = StKsAdd;
      end
      // Key schedule: j += S[n] + key byte, then read S[j].
      StKsAdd: begin
        sum       = j_q + mem_rdata_q + key_byte;
        si_d      = mem_rdata_q;
        j_d       = sum;
        mem_raddr = sum;
        state_d   = StKsWrN;
      end
      // Key schedule: S[n] takes the old S[j].
      StKsWrN: begin
        mem_we    = 1'b1;
        mem_waddr = n_q;
        mem_wdata = mem_rdata_q;
        state_d   = StKsWrJ;
      end
      // Key schedule: S[j] takes the old S[n]; advance the key position.
      StKsWrJ: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = si_q;
        n_d       = n_q + BW'(1);
        if (rc4_pkg::KeyLenW'(k_q) + rc4_pkg::KeyLenW'(1) >= key_i.len) begin
          k_d = '0;
        end else begin
          k_d = k_q + rc4_pkg::KeyIdxW'(1);
        end
        if (n_q == BW'(rc4_pkg::PermSize - 1)) begin
          i_d     = '0;
          j_d     = '0;
          keyed_d = 1'b1;
          state_d = StGenI;
        end else begin
          state_d = StKsRead;
        end
      end
      // Generator: advance i and read S[i].
      StGenI: begin
        sum       = i_q + BW'(1);
        i_d       = sum;
        mem_raddr = sum;
        state_d   = StGenJ;
      end
      // Generator: j += S[i], then read S[j].
      StGenJ: begin
        sum       = j_q + mem_rdata_q;
        si_d      = mem_rdata_q;
        j_d       = sum;
        mem_raddr = sum;
        state_d   = StGenWrI;
      end
      // Generator: S[i] takes S[j]; read the keystream entry.
      StGenWrI: begin
        sum       = si_q + mem_rdata_q;
        sj_d      = mem_rdata_q;
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = mem_rdata_q;
        mem_raddr = sum;
        t_d       = sum;
        state_d   = StGenWrJ;
      end
      // Generator: S[j] takes S[i]; forward the swapped entries to the keystream.
      StGenWrJ: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = si_q;
        if (t_q == j_q) begin
          ks_d = si_q;
        end else if (t_q == i_q) begin
          ks_d = sj_q;
        end else begin
          ks_d = mem_rdata_q;
        end
        state_d = StDeliver;
      end
      // Hand the result to the output register once it is free.
      StDeliver: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = data_q ^ ks_q;
          out_ks_d    = ks_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      i_q         <= '0;
      j_q         <= '0;
      keyed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      keyed_q     <= keyed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    k_q       <= k_d;
    si_q      <= si_d;
    sj_q      <= sj_d;
    t_q       <= t_d;
    ks_q      <= ks_d;
    data_q    <= data_d;
    out_res_q <= out_res_d;
    out_ks_q  <= out_ks_d;
  end

  assign in_i.ready           = (state_q == StIdle);
  assign out_o.valid          = out_valid_q;
  assign out_o.result_byte    = out_res_q;
  assign out_o.keystream_byte = out_ks_q;

endmodule

// ===== tb/rc4_stream_cipher_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RC4 stream cipher checker
// Watches the configuration port and both byte channels of the cipher. It
// keeps its own copy of the key registers, the permutation and the indices,
// works out the result and keystream byte for every accepted input byte, and
// compares each result transfer against the oldest pending prediction.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration port, observed only.
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic                         pready_i,
  input  logic [rc4_pkg::CfgAddrW-1:0] paddr_i,
  input  logic [rc4_pkg::CfgDataW-1:0] pwdata_i,
  // Input byte channel.
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [rc4_pkg::ByteW-1:0]    data_byte_i,
  input  logic                         restart_i,
  // Result channel.
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [rc4_pkg::ByteW-1:0]    result_byte_i,
  input  logic [rc4_pkg::ByteW-1:0]    keystream_byte_i,
  // Status for the test top.
  output int                           pending_o,
  output int                           errors_o
);

  // Only the first few mismatches are printed; all of them are counted.
  localparam int PrintLimit = 40;

  typedef struct packed {
    logic [rc4_pkg::ByteW-1:0] result_byte;
    logic [rc4_pkg::ByteW-1:0] keystream_byte;
  } cipher_out_t;

  cipher_out_t                  expected_out_q [$];
  cipher_out_t                  oldest_out;
  logic [rc4_pkg::ByteW-1:0]    sbox [rc4_pkg::PermSize];
  logic [rc4_pkg::ByteW-1:0]    ptr_i;
  logic [rc4_pkg::ByteW-1:0]    ptr_j;
  logic                         keyed;
  logic [rc4_pkg::CfgDataW-1:0] key_lo;
  logic [rc4_pkg::CfgDataW-1:0] key_hi;
  logic [rc4_pkg::KeyLenW-1:0]  key_len;
  int                           err_count;

  // Print one line for a failure and count it.
  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= PrintLimit) begin
      $display("[%0t] rc4 checker: %s", $realtime, msg);
    end
  endtask

  // Key byte at a position of the 16-byte key, byte 0 in the low bits.
  function automatic logic [rc4_pkg::ByteW-1:0] key_byte(input int unsigned pos);
    logic [rc4_pkg::CfgDataW-1:0] word;
    word = (pos < 8) ? key_lo : key_hi;
    return word[(pos % 8) * 8 +: 8];
  endfunction

  // Key schedule: identity permutation, 256 keyed swaps, indices cleared.
  function automatic void run_key_schedule();
    int unsigned               len;
    int                        n;
    logic [rc4_pkg::ByteW-1:0] jj;
    logic [rc4_pkg::ByteW-1:0] tmp;
    len = key_len;
    if (len < 1) len = 1;
    if (len > rc4_pkg::MaxKeyBytes) len = rc4_pkg::MaxKeyBytes;
    for (n = 0; n < rc4_pkg::PermSize; n++) begin
      sbox[n] = rc4_pkg::ByteW'(n);
    end
    jj = '0;
    for (n = 0; n < rc4_pkg::PermSize; n++) begin
      jj = jj + sbox[n] + key_byte(n % len);
      tmp = sbox[n];
      sbox[n] = sbox[jj];
      sbox[jj] = tmp;
    end
    ptr_i = '0;
    ptr_j = '0;
    keyed = 1'b1;
  endfunction

  // One generator step for one data byte.
  function automatic cipher_out_t next_cipher_byte(
      input logic [rc4_pkg::ByteW-1:0] data,
      input logic                      restart);
    logic [rc4_pkg::ByteW-1:0] si;
    logic [rc4_pkg::ByteW-1:0] sj;
    logic [rc4_pkg::ByteW-1:0] ks_idx;
    cipher_out_t               res;
    if (restart || !keyed) run_key_schedule();
    ptr_i = ptr_i + 8'd1;
    ptr_j = ptr_j + sbox[ptr_i];
    si = sbox[ptr_i];
    sj = sbox[ptr_j];
    sbox[ptr_i] = sj;
    sbox[ptr_j] = si;
    ks_idx = si + sj;
    res.keystream_byte = sbox[ks_idx];
    res.result_byte    = data ^ sbox[ks_idx];
    return res;
  endfunction

  // Results are checked before new input bytes are predicted, since a result
  // never belongs to a byte taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_out_q.delete();
      ptr_i     = '0;
      ptr_j     = '0;
      keyed     = 1'b0;
      key_lo    = '0;
      key_hi    = '0;
      key_len   = rc4_pkg::KeyLenW'(rc4_pkg::MaxKeyBytes);
      err_count = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      // Compare a result transfer with the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        if (expected_out_q.size() == 0) begin
          report_mismatch($sformatf("result %02h keystream %02h with no byte pending",
                                    result_byte_i, keystream_byte_i));
        end else begin
          oldest_out = expected_out_q.pop_front();
          if (result_byte_i !== oldest_out.result_byte) begin
            report_mismatch($sformatf("result_byte %02h, expected %02h",
                                      result_byte_i, oldest_out.result_byte));
          end
          if (keystream_byte_i !== oldest_out.keystream_byte) begin
            report_mismatch($sformatf("keystream_byte %02h, expected %02h",
                                      keystream_byte_i, oldest_out.keystream_byte));
          end
        end
      end

      // Predict the result of an input transfer.
      if (in_valid_i && in_ready_i) begin
        expected_out_q.push_back(next_cipher_byte(data_byte_i, restart_i));
      end

      // Track register writes; unknown indexes are ignored.
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[rc4_pkg::CfgAddrW-1:3])
          rc4_pkg::RegKeyLow:  key_lo = pwdata_i;
          rc4_pkg::RegKeyHigh: key_hi = pwdata_i;
          rc4_pkg::RegKeyLen:  key_len = pwdata_i[rc4_pkg::KeyLenW-1:0];
          default: ;
        endcase
      end

      pending_o <= expected_out_q.size();
      errors_o  <= err_count;
    end
  end

endmodule

// ===== tb/rc4_stream_cipher_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RC4 stream cipher test
// Drives the cipher with a directed opening (reset key, all-ones key, key
// lengths zero, one, sixteen and above sixteen, an unused register address,
// key changes without restart) and then random streams of restart-led runs
// under three idling patterns, including one long receiver hold-off. A
// checker beside the block predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_test;

  localparam logic [1:0] RegUnused   = 2'd3;
  localparam int         CycleLimit  = 4_000_000;
  localparam int         DrainCycles = 50;
  localparam int         LongHold    = 300;
  localparam int         PhaseItems  = 150;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [rc4_pkg::CfgAddrW-1:0] paddr;
  logic [rc4_pkg::CfgDataW-1:0] pwdata;
  logic [rc4_pkg::CfgDataW-1:0] prdata;
  logic                         pready;

  int pending_bytes;
  int error_total;
  int cycle_count;
  int tx_idle_pct;
  int rx_idle_pct;
  int stall_seq;
  int stall_seen;
  int hold_left;

  rc4_in_if  in_ch ();
  rc4_out_if out_ch ();

  rc4_stream_cipher dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  rc4_stream_cipher_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .in_valid_i       (in_ch.valid),
    .in_ready_i       (in_ch.ready),
    .data_byte_i      (in_ch.data_byte),
    .restart_i        (in_ch.restart),
    .out_valid_i      (out_ch.valid),
    .out_ready_i      (out_ch.ready),
    .result_byte_i    (out_ch.result_byte),
    .keystream_byte_i (out_ch.keystream_byte),
    .pending_o        (pending_bytes),
    .errors_o         (error_total)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("rc4_stream_cipher_test: done, errors");
      $finish;
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_seq != stall_seen) begin
        stall_seen = stall_seq;
        hold_left  = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // One input byte transfer, after random idle cycles.
  task automatic send_byte(input logic [rc4_pkg::ByteW-1:0] value,
                           input logic restart_flag);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= value;
    in_ch.restart   <= restart_flag;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [1:0] idx,
                           input logic [rc4_pkg::CfgDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop offering bytes and wait until every predicted result has arrived.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes != 0) @(posedge clk_i);
  endtask

  // Stimulus and verdict.
  initial begin
    int                          p;
    int                          sent;
    int                          run_len;
    int                          k;
    logic                        rs;
    logic [rc4_pkg::KeyLenW-1:0] len;

    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.restart   <= 1'b0;
    tx_idle_pct = 20;
    rx_idle_pct <= 57;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset key: the first byte schedules even without restart.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);

    // All-ones key; the first byte still runs on the old schedule.
    drain_results();
    write_reg(rc4_pkg::RegKeyLow, '1);
    write_reg(rc4_pkg::RegKeyHigh, '1);
    write_reg(rc4_pkg::RegKeyLen, rc4_pkg::CfgDataW'(rc4_pkg::MaxKeyBytes));
    write_reg(RegUnused, {$urandom, $urandom});
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hA5, 1'b0);

    // Key length zero behaves as one.
    drain_results();
    write_reg(rc4_pkg::RegKeyLow, {$urandom, $urandom});
    write_reg(rc4_pkg::RegKeyLen, '0);
    send_byte(8'h3C, 1'b1);
    send_byte(8'hC3, 1'b0);

    // Lengths above sixteen saturate.
    drain_results();
    write_reg(rc4_pkg::RegKeyLen, rc4_pkg::CfgDataW'(31));
    send_byte(8'h0F, 1'b1);
    send_byte(8'hF0, 1'b0);
    drain_results();
    write_reg(rc4_pkg::RegKeyHigh, {$urandom, $urandom});
    write_reg(rc4_pkg::RegKeyLen, rc4_pkg::CfgDataW'(17));
    send_byte(8'h81, 1'b1);

    // Single-byte key.
    drain_results();
    write_reg(rc4_pkg::RegKeyLen, rc4_pkg::CfgDataW'(1));
    send_byte(8'h7E, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);

    // Random phases: each opens with a new key but no restart, so the first
    // run continues the previous schedule. Phases 0 and 1 together carry one
    // run long enough to wrap the index.
    for (p = 0; p < 3; p++) begin
      drain_results();
      case (p)
        0: begin
          tx_idle_pct = 20;
          rx_idle_pct <= 57;
        end
        1: begin
          tx_idle_pct = 57;
          rx_idle_pct <= 20;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(0, 1) ? rc4_pkg::KeyLenW'(0)
                                   : rc4_pkg::KeyLenW'($urandom_range(17, 31));
      end else begin
        len = rc4_pkg::KeyLenW'($urandom_range(1, 16));
      end
      write_reg(rc4_pkg::RegKeyLow, {$urandom, $urandom});
      write_reg(rc4_pkg::RegKeyHigh, {$urandom, $urandom});
      write_reg(rc4_pkg::RegKeyLen, rc4_pkg::CfgDataW'(len));
      if (p == 1) write_reg(RegUnused, {$urandom, $urandom});

      sent = 0;
      run_len = (p == 0) ? PhaseItems : (p == 1) ? 130 : $urandom_range(1, 24);
      while (sent < PhaseItems) begin
        for (k = 0; k < run_len && sent < PhaseItems; k++) begin
          // A run after a phase's first opens with restart; stray restarts inside it are noise.
          rs = (k == 0 && sent != 0) ? 1'b1 : ($urandom_range(0, 49) == 0);
          send_byte(rc4_pkg::ByteW'($urandom_range(0, 255)), rs);
          sent++;
          // Hold the receiver off while bytes keep coming.
          if (p == 2 && sent == 10) stall_seq <= stall_seq + 1;
        end
        run_len = $urandom_range(1, 24);
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_total == 0) begin
      $display("rc4_stream_cipher_test: done, clean");
    end else begin
      $display("rc4_stream_cipher_test: done, errors");
    end
    $finish;
  end

endmodule
